// File: design/mbps_pkg.sv
package mbps_pkg;

   localparam int CSR_DATA_WIDTH  = 64;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int PATTERN_BYTES   = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_LOW    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_HIGH   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BYTE_MASK      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_LENGTH = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BASE_ADDRESS   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEARCH_LENGTH  = 3'd5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_scan;
   } req_payload_type;

   typedef struct packed {
      logic        found;
      logic [31:0] match_address;
   } rsp_payload_type;

   // Pattern settings shared by every cell; the length is already clamped.
   typedef struct packed {
      logic [8*PATTERN_BYTES-1:0] pattern;
      logic [PATTERN_BYTES-1:0]   byte_mask;
      logic [4:0]                 pattern_length;
   } cell_cfg_type;

endpackage

// File: design/masked_byte_pattern_search.sv
// Streams memory bytes, one per transfer, and reports the first address at which a masked
// pattern of up to MAX_PATTERN bytes matches. The byte flagged with start_scan sits at the
// base address and restarts the scan; a scan fed to its end gives exactly one result
// transfer, either found with the match address or not found once the last candidate offset
// has been judged. Bytes outside a scan are taken and dropped. A byte is taken every cycle:
// the window is a row of MAX_PATTERN byte cells that shift and compare in parallel, and the
// verdict for the byte just taken is registered in the output stage, so its result appears
// in the next cycle, and input stalls only while a result waits to be taken.
module masked_byte_pattern_search #(
   parameter int MAX_PATTERN = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  mbps_pkg::req_payload_type                req_payload,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output mbps_pkg::rsp_payload_type                rsp_payload,
   input  logic                                     csr_we,
   input  logic [mbps_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [mbps_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata
);
   import mbps_pkg::*;

   localparam logic [32:0] SEEN_MAX = {33{1'b1}};

   logic [63:0]            pattern_low_ff;
   logic [63:0]            pattern_high_ff;
   logic [15:0]            byte_mask_ff;
   logic [4:0]             pattern_length_ff;
   logic [31:0]            base_address_ff;
   logic [31:0]            search_length_ff;

   logic                   scan_done_ff, scan_done_in;
   logic [32:0]            bytes_seen_ff, bytes_seen_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_payload_ff, rsp_payload_in;

   cell_cfg_type           cell_cfg;
   logic [MAX_PATTERN-1:0] hit_vec;
   logic [7:0]             chain [MAX_PATTERN];
   logic                   accept;
   logic                   active;
   logic [4:0]             len_clamped;
   logic [4:0]             len_eff;
   logic [32:0]            seen_base;
   logic [32:0]            seen_next;
   logic [32:0]            cand;
   logic [32:0]            limit;
   logic                   result_fire;
   logic                   result_found;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign active    = accept && (req_payload.start_scan || !scan_done_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         byte_mask_ff      <= 16'hFFFF;
         pattern_length_ff <= 5'd1;
         base_address_ff   <= '0;
         search_length_ff  <= 32'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:    pattern_low_ff    <= csr_wdata;
            CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_wdata;
            CSR_BYTE_MASK:      byte_mask_ff      <= csr_wdata[15:0];
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_wdata[4:0];
            CSR_BASE_ADDRESS:   base_address_ff   <= csr_wdata[31:0];
            CSR_SEARCH_LENGTH:  search_length_ff  <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      len_clamped = (pattern_length_ff > 5'(MAX_PATTERN)) ? 5'(MAX_PATTERN)
                                                          : pattern_length_ff;
      len_eff     = (len_clamped == 5'd0) ? 5'd1 : len_clamped;
      cell_cfg.pattern        = {pattern_high_ff, pattern_low_ff};
      cell_cfg.byte_mask      = byte_mask_ff;
      cell_cfg.pattern_length = len_clamped;
   end

   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      logic [7:0] cell_in;
      if (j == 0) begin : g_head
         assign cell_in = req_payload.data_byte;
      end else begin : g_body
         assign cell_in = chain[j-1];
      end
      mbps_cell #(.INDEX(j)) u_cell (
         .clock    (clock),
         .shift_en (active),
         .shift_in (cell_in),
         .cfg      (cell_cfg),
         .byte_out (chain[j]),
         .hit      (hit_vec[j])
      );
   end

   // The verdict is taken on the window as it stands once this byte has shifted in.
   always_comb begin
      seen_base    = req_payload.start_scan ? '0 : bytes_seen_ff;
      seen_next    = (seen_base == SEEN_MAX) ? seen_base : seen_base + 33'd1;
      cand         = seen_next - {28'd0, len_eff};
      limit        = {1'b0, search_length_ff};
      result_fire  = 1'b0;
      result_found = 1'b0;
      if (active) begin
         priority if (search_length_ff == 32'd0) begin
            result_fire = 1'b1;
         end else if (seen_next >= {28'd0, len_eff}) begin
            if ((cand < limit) && (&hit_vec)) begin
               result_fire  = 1'b1;
               result_found = 1'b1;
            end else if (cand >= limit - 33'd1) begin
               result_fire = 1'b1;
            end
         end else begin
            result_fire = 1'b0;
         end
      end

      scan_done_in  = scan_done_ff;
      bytes_seen_in = bytes_seen_ff;
      if (active) begin
         bytes_seen_in = seen_next;
         scan_done_in  = result_fire;
      end

      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      if (result_fire) begin
         rsp_valid_in                 = 1'b1;
         rsp_payload_in.found         = result_found;
         rsp_payload_in.match_address = result_found ? base_address_ff + cand[31:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_done_ff  <= 1'b1;
         bytes_seen_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         scan_done_ff  <= scan_done_in;
         bytes_seen_ff <= bytes_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   a_result_needs_byte: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(active))
      else $error("result appeared without a byte taken in a scan");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_payload_ff.found |-> rsp_payload_ff.match_address == 32'd0)
      else $error("not-found result carries a non-zero address");

   a_done_after_result: assert property (@(posedge clock) disable iff (reset)
      result_fire |=> scan_done_ff)
      else $error("scan still running after its result");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      active && !req_payload.start_scan |=> bytes_seen_ff >= $past(bytes_seen_ff))
      else $error("byte count went backwards within a scan");
`endif

endmodule

// File: design/mbps_cell.sv
module mbps_cell #(
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  logic                  shift_en,
   input  logic [7:0]            shift_in,
   input  mbps_pkg::cell_cfg_type cfg,
   output logic [7:0]            byte_out,
   output logic                  hit
);
   import mbps_pkg::*;

   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic [3:0] pat_sel;
   logic [7:0] pat_byte;
   logic       care;

   // Cell j holds window entry j, which lines up with pattern byte length-1-j.
   always_comb begin
      pat_sel  = 4'(cfg.pattern_length - 5'd1 - 5'(INDEX));
      care     = (5'(INDEX) < cfg.pattern_length) && cfg.byte_mask[pat_sel];
      pat_byte = cfg.pattern[{pat_sel, 3'b000} +: 8];
      hit      = !care || (shift_in == pat_byte);
      byte_in  = shift_en ? shift_in : byte_ff;
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign byte_out = byte_ff;

endmodule

// File: tb/mbps_result_checker.sv
module mbps_result_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  mbps_pkg::req_payload_type            req_payload,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  mbps_pkg::rsp_payload_type            rsp_payload,
   input  logic                                 csr_we,
   input  logic [mbps_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mbps_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                                 end_of_run,
   output int                                   failures,
   output int                                   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import mbps_pkg::*;

   // Shadow copy of the search registers.
   logic [63:0] cfg_pattern_low;
   logic [63:0] cfg_pattern_high;
   logic [15:0] cfg_byte_mask;
   logic [4:0]  cfg_pattern_length;
   logic [31:0] cfg_base_address;
   logic [31:0] cfg_search_length;

   // Scan state: entry 0 of the window holds the newest byte.
   logic [7:0]  recent_bytes [16];
   logic [32:0] scan_byte_count;
   logic        scan_finished;

   rsp_payload_type verdicts_due [$];
   rsp_payload_type oldest_due;
   int mismatch_count = 0;
   int due_count      = 0;
   bit end_checked    = 1'b0;

   assign failures    = mismatch_count;
   assign outstanding = due_count;

   task automatic report_mismatch(input string what);
      if (mismatch_count < 100) $display("%0d ns mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic void expect_verdict(input logic hit, input logic [31:0] address);
      rsp_payload_type verdict;
      verdict.found         = hit;
      verdict.match_address = address;
      verdicts_due.push_back(verdict);
      due_count++;
   endfunction

   function automatic void predict_scan_step(input logic [7:0] data, input logic start);
      int unsigned  len;
      int unsigned  eff;
      logic [63:0]  cand;
      logic [127:0] pattern;
      logic         hit;
      if (start) begin
         scan_byte_count = '0;
         scan_finished   = 1'b0;
      end
      // Outside a scan the byte is dropped without touching the window.
      if (scan_finished) return;
      for (int i = 15; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
      recent_bytes[0] = data;
      if (scan_byte_count != '1) scan_byte_count++;
      len = (cfg_pattern_length > 5'd16) ? 16 : cfg_pattern_length;
      eff = (len == 0) ? 1 : len;
      if (cfg_search_length == '0) begin
         scan_finished = 1'b1;
         expect_verdict(1'b0, '0);
         return;
      end
      if (scan_byte_count < eff) return;
      cand    = 64'(scan_byte_count) - 64'(eff);
      pattern = {cfg_pattern_high, cfg_pattern_low};
      hit     = 1'b1;
      for (int k = 0; k < len; k++) begin
         if (cfg_byte_mask[k] && recent_bytes[eff-1-k] != pattern[8*k +: 8]) hit = 1'b0;
      end
      if (cand < 64'(cfg_search_length) && hit) begin
         scan_finished = 1'b1;
         expect_verdict(1'b1, cfg_base_address + cand[31:0]);
      end else if (cand >= 64'(cfg_search_length) - 64'd1) begin
         // Also taken when a shorter limit was written while the scan was under way.
         scan_finished = 1'b1;
         expect_verdict(1'b0, '0);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_pattern_low    = '0;
         cfg_pattern_high   = '0;
         cfg_byte_mask      = 16'hFFFF;
         cfg_pattern_length = 5'd1;
         cfg_base_address   = '0;
         cfg_search_length  = 32'd1;
         for (int i = 0; i < 16; i++) recent_bytes[i] = '0;
         scan_byte_count = '0;
         scan_finished   = 1'b1;
         verdicts_due.delete();
         due_count = 0;
      end else begin
         // A result leaves no earlier than the cycle after the byte that decides it, so the
         // comparison comes before this edge's prediction.
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               report_mismatch($sformatf("result transfer with none due: found=%0b address=%h",
                                         rsp_payload.found, rsp_payload.match_address));
            end else begin
               oldest_due = verdicts_due.pop_front();
               due_count--;
               if (rsp_payload.found !== oldest_due.found)
                  report_mismatch($sformatf("found is %0b, expected %0b",
                                            rsp_payload.found, oldest_due.found));
               if (rsp_payload.match_address !== oldest_due.match_address)
                  report_mismatch($sformatf("match_address is %h, expected %h",
                                            rsp_payload.match_address,
                                            oldest_due.match_address));
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_PATTERN_LOW:    cfg_pattern_low    = csr_wdata;
               CSR_PATTERN_HIGH:   cfg_pattern_high   = csr_wdata;
               CSR_BYTE_MASK:      cfg_byte_mask      = csr_wdata[15:0];
               CSR_PATTERN_LENGTH: cfg_pattern_length = csr_wdata[4:0];
               CSR_BASE_ADDRESS:   cfg_base_address   = csr_wdata[31:0];
               CSR_SEARCH_LENGTH:  cfg_search_length  = csr_wdata[31:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            predict_scan_step(req_payload.data_byte, req_payload.start_scan);
         if (end_of_run && !end_checked) begin
            end_checked = 1'b1;
            if (due_count != 0)
               report_mismatch($sformatf("%0d results never arrived", due_count));
         end
      end
   end

endmodule

// File: tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mbps_pkg::*;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED_A = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED_B = 3'd7;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int SCAN_SPAN_CAP    = 24;
   localparam int RANDOM_ITEMS     = 1250;

   typedef struct packed {
      logic [63:0] pattern_low;
      logic [63:0] pattern_high;
      logic [15:0] byte_mask;
      logic [4:0]  pattern_length;
      logic [31:0] base_address;
      logic [31:0] search_length;
   } search_setup_type;

   logic                        clock       = 1'b0;
   logic                        reset       = 1'b1;
   logic                        req_valid   = 1'b0;
   logic                        req_ready;
   req_payload_type             req_payload = '0;
   logic                        rsp_valid;
   logic                        rsp_ready   = 1'b0;
   rsp_payload_type             rsp_payload;
   logic                        csr_we      = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index   = '0;
   logic [CSR_DATA_WIDTH-1:0]   csr_wdata   = '0;
   logic                        end_of_run  = 1'b0;
   int                          failures;
   int                          outstanding;

   bit               send_gaps    = 1'b1;
   bit               recv_gaps    = 1'b1;
   bit               hold_request = 1'b0;
   search_setup_type setup;
   int unsigned      items_sent   = 0;

   masked_byte_pattern_search DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   mbps_result_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .end_of_run  (end_of_run),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   task automatic send_byte(input logic [7:0] value, input logic start);
      int unsigned gap;
      gap = send_gaps ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_payload <= '{data_byte: value, start_scan: start};
      req_valid   <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      items_sent++;
   endtask

   // Waits until every due result has been taken and the pipeline has had time to
   // finish a byte that decides nothing.
   task automatic settle();
      req_valid <= 1'b0;
      repeat (4) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_setup(input search_setup_type s);
      logic [CSR_INDEX_WIDTH-1:0] index_list [8];
      logic [CSR_DATA_WIDTH-1:0]  value_list [8];
      index_list = '{CSR_PATTERN_LOW, CSR_PATTERN_HIGH, CSR_BYTE_MASK, CSR_PATTERN_LENGTH,
                     CSR_BASE_ADDRESS, CSR_SEARCH_LENGTH, CSR_UNMAPPED_A, CSR_UNMAPPED_B};
      // Bits above each register's width carry noise and must be dropped.
      value_list = '{s.pattern_low,
                     s.pattern_high,
                     {$urandom, 16'($urandom), s.byte_mask},
                     {$urandom, 27'($urandom), s.pattern_length},
                     {$urandom, s.base_address},
                     {$urandom, s.search_length},
                     {$urandom, $urandom},
                     {$urandom, $urandom}};
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= index_list[i];
         csr_wdata <= value_list[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      setup = s;
   endtask

   function automatic search_setup_type random_setup();
      search_setup_type s;
      int unsigned      pick;
      s.pattern_low  = {$urandom, $urandom};
      s.pattern_high = {$urandom, $urandom};
      pick = $urandom_range(0, 7);
      case (pick)
         0:       s.byte_mask = '0;
         1:       s.byte_mask = '1;
         2:       s.byte_mask = 16'($urandom | $urandom);
         default: s.byte_mask = 16'($urandom);
      endcase
      pick = $urandom_range(0, 19);
      case (pick)
         0:       s.pattern_length = '0;
         1:       s.pattern_length = 5'($urandom_range(17, 31));
         2:       s.pattern_length = 5'd16;
         default: s.pattern_length = 5'($urandom_range(1, 16));
      endcase
      pick = $urandom_range(0, 7);
      case (pick)
         0:       s.base_address = '0;
         1:       s.base_address = 32'hFFFF_FFFF - $urandom_range(0, 24);
         default: s.base_address = $urandom;
      endcase
      pick = $urandom_range(0, 11);
      case (pick)
         0:       s.search_length = '0;
         1:       s.search_length = '1;
         2:       s.search_length = $urandom;
         default: s.search_length = $urandom_range(1, SCAN_SPAN_CAP);
      endcase
      return s;
   endfunction

   // One scan: a start byte and enough bytes to judge every candidate up to the cap.
   // Filler leans on pattern bytes so that near misses are common, and most scans
   // carry a planted copy of the pattern at an offset anywhere from zero up to the cap.
   task automatic run_scan();
      logic [7:0]   stream [64];
      logic [127:0] pattern;
      int unsigned  len;
      int unsigned  eff;
      int unsigned  cap;
      int unsigned  total;
      int unsigned  spot;
      pattern = {setup.pattern_high, setup.pattern_low};
      len   = (setup.pattern_length > 5'd16) ? 16 : setup.pattern_length;
      eff   = (len == 0) ? 1 : len;
      cap   = (setup.search_length > SCAN_SPAN_CAP) ? SCAN_SPAN_CAP : setup.search_length;
      total = cap + eff + $urandom_range(0, 3);
      for (int i = 0; i < total; i++) begin
         if ($urandom_range(0, 1) != 0) stream[i] = 8'($urandom);
         else stream[i] = pattern[8*$urandom_range(0, 15) +: 8];
      end
      if ($urandom_range(0, 3) != 0) begin
         spot = $urandom_range(0, cap);
         for (int k = 0; k < len; k++) begin
            if (setup.byte_mask[k]) stream[spot+k] = pattern[8*k +: 8];
         end
      end
      for (int i = 0; i < total; i++) begin
         send_byte(stream[i], (i == 0) || ($urandom_range(0, 39) == 0));
      end
   endtask

   initial begin : result_sink
      int unsigned wait_cycles;
      wait (!reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            wait_cycles  = LONG_HOLD_CYCLES;
         end else begin
            wait_cycles = recv_gaps ? $urandom_range(0, 7) : 0;
         end
         if (wait_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   initial begin : stimulus
      search_setup_type s;
      setup = '{pattern_low: '0, pattern_high: '0, byte_mask: 16'hFFFF, pattern_length: 5'd1,
                base_address: '0, search_length: 32'd1};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: a byte outside a scan is dropped, then a hit and a miss.
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      settle();

      // Zero pattern length at the top of the address space.
      s = '{pattern_low: {$urandom, $urandom}, pattern_high: {$urandom, $urandom},
            byte_mask: 16'hFFFF, pattern_length: 5'd0, base_address: 32'hFFFF_FFFF,
            search_length: 32'd5};
      apply_setup(s);
      send_byte(8'h3C, 1'b1);
      send_byte(8'hC3, 1'b0);
      settle();

      // Zero search length ends the scan on its first byte.
      s.pattern_length = 5'd16;
      s.base_address   = '0;
      s.search_length  = '0;
      apply_setup(s);
      send_byte(8'h00, 1'b1);
      settle();

      // Length above range with only the end bytes compared; the second candidate hits.
      s = '{pattern_low: {$urandom, 24'($urandom), 8'hA5},
            pattern_high: {8'h5A, 24'($urandom), $urandom},
            byte_mask: 16'h8001, pattern_length: 5'd31, base_address: 32'h0000_1000,
            search_length: 32'd2};
      apply_setup(s);
      send_byte(8'h00, 1'b1);
      send_byte(8'hA5, 1'b0);
      repeat (13) send_byte(8'($urandom), 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h5A, 1'b0);
      settle();

      // Every start byte hits at once while the receiver holds off, so the input backs up.
      s = '{pattern_low: {$urandom, $urandom}, pattern_high: {$urandom, $urandom},
            byte_mask: '0, pattern_length: 5'd1, base_address: $urandom,
            search_length: 32'd1};
      apply_setup(s);
      send_gaps    = 1'b0;
      hold_request = 1'b1;
      repeat (30) send_byte(8'($urandom), 1'b1);
      send_gaps = 1'b1;

      while (items_sent < RANDOM_ITEMS) begin
         // A scan left open by the last phase runs on under the new settings.
         settle();
         apply_setup(random_setup());
         send_gaps = ($urandom_range(0, 3) != 0);
         recv_gaps = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(1, 4)) begin
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
            run_scan();
         end
      end

      settle();
      end_of_run <= 1'b1;
      repeat (2) @(posedge clock);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// File: filelist.f
design/mbps_pkg.sv
design/mbps_cell.sv
design/masked_byte_pattern_search.sv
tb/mbps_result_checker.sv
tb/tb_top.sv
